// ===== design/frame_slot_mailbox_manager_macros.svh =====
// Assertion helpers used by the top design file.
`ifndef FRAME_SLOT_MAILBOX_MANAGER_MACROS_SVH
`define FRAME_SLOT_MAILBOX_MANAGER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define FSMM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define FSMM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fsmm_pkg.sv =====
`timescale 1ns / 1ps

package fsmm_pkg;

    localparam int ACT_W   = 3;
    localparam int IDX_IN_W = 3;
    localparam int FRAME_W = 64;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 2;
    localparam int CNT_W   = 3;

    localparam logic [ACT_W-1:0] ACT_ACQUIRE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUBLISH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PRESENT  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 3'd3;

    typedef enum logic [1:0] {
        PH_FREE     = 2'd0,
        PH_INFLIGHT = 2'd1,
        PH_PENDING  = 2'd2,
        PH_READY    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_LATCH,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } fsmm_state_t;

endpackage

// ===== design/fsmm_frame_ram.sv =====
`timescale 1ns / 1ps

module fsmm_frame_ram #(
    parameter int DEPTH = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [fsmm_pkg::FRAME_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [fsmm_pkg::FRAME_W-1:0] rdata
);
    import fsmm_pkg::*;

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/frame_slot_mailbox_manager.sv =====
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------------------------------
// request   | in_valid / in_stall   | action, slot_index, frame_number, already_done
// response  | out_valid / out_stall | status, slot_out, frame_out
// config    | cfg_we                | cfg_wdata (active_slots)
//
// Publish, complete, bad-slot and unknown actions go straight from idle to finish.
// Acquire and query scan the n active slots, n = active slot count; one slot per cycle through
// the frame RAM read port and a single 64-bit comparator. Present reads the presented
// slot's frame first, then scans the same way.
// Reset clears all slots to free, finished bits to zero and active_slots to 3.
// A held response (out_stall) blocks the next response, not the work before it.
`timescale 1ns / 1ps
`include "frame_slot_mailbox_manager_macros.svh"

module frame_slot_mailbox_manager #(
    parameter int MAX_SLOTS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fsmm_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fsmm_pkg::ACT_W-1:0]    action,
    input  logic [fsmm_pkg::IDX_IN_W-1:0] slot_index,
    input  logic [fsmm_pkg::FRAME_W-1:0]  frame_number,
    input  logic                          already_done,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fsmm_pkg::STAT_W-1:0]   status,
    output logic [fsmm_pkg::SLOT_W-1:0]   slot_out,
    output logic [fsmm_pkg::FRAME_W-1:0]  frame_out
);
    import fsmm_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);

    fsmm_state_t state_reg, state_next;

    logic [CNT_W-1:0]   active_reg;
    phase_t             phase_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] fin_reg;

    logic [ACT_W-1:0]   op_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic               eval_vld_reg;
    logic               found_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    logic [FRAME_W-1:0] key_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [FRAME_W-1:0] frame_out_reg;

    logic [CNT_W-1:0]   used_n;
    logic               accept;
    logic               in_bad;
    logic [IDX_W-1:0]   in_slot;
    logic               scan_last;
    logic               out_free;
    logic [IDX_W-1:0]   rd_addr;
    logic [FRAME_W-1:0] rd_data;
    logic               ram_we;
    phase_t             eval_phase;
    logic               eval_fin;
    logic               key_lt;
    logic               promote;
    logic               take;
    logic               drop;
    logic               acq_hit;

    // Counts above the built slot count fall back to it.
    assign used_n    = (32'(active_reg) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : active_reg;
    assign accept    = in_valid && !in_stall;
    assign in_bad    = (slot_index >= used_n);
    assign in_slot   = IDX_W'(slot_index);
    assign scan_last = ((32'(scan_idx_reg) + 32'd1) == 32'(used_n));
    assign out_free  = !out_valid_reg || !out_stall;

    assign rd_addr = (state_reg == S_PRE) ? tgt_reg : scan_idx_reg;
    assign ram_we  = accept && (action == ACT_PUBLISH) && !in_bad;

    fsmm_frame_ram #(
        .DEPTH (MAX_SLOTS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_slot),
        .wdata (frame_number),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Shared comparator: query picks strictly higher, present drops not-above.
    assign eval_phase = phase_reg[eval_idx_reg];
    assign eval_fin   = fin_reg[eval_idx_reg];
    assign key_lt     = (rd_data > key_reg);
    assign promote    = (eval_phase == PH_PENDING) && eval_fin;
    assign take       = ((eval_phase == PH_READY) || promote) && (!found_reg || key_lt);
    assign drop       = (eval_phase == PH_READY) && !key_lt;
    assign acq_hit    = !found_reg && (eval_phase == PH_FREE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action) inside
                        ACT_ACQUIRE, ACT_QUERY:
                            state_next = (used_n == '0) ? S_FINISH : S_SCAN;
                        ACT_PRESENT:
                            state_next = in_bad ? S_FINISH : S_PRE;
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_PRE:    state_next = S_LATCH;
            S_LATCH:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Slot status, config and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= ACTIVE_RESET;
            fin_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                phase_reg[i] <= PH_FREE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            eval_vld_reg <= (state_reg == S_SCAN);
            if (accept)
            begin
                found_reg <= 1'b0;
                if (!in_bad && (action == ACT_PUBLISH))
                begin
                    phase_reg[in_slot] <= PH_PENDING;
                    fin_reg[in_slot]   <= already_done;
                end
                if (!in_bad && (action == ACT_COMPLETE))
                begin
                    fin_reg[in_slot] <= 1'b1;
                end
            end
            if (eval_vld_reg)
            begin
                case (op_reg)
                    ACT_ACQUIRE:
                    begin
                        if (acq_hit)
                        begin
                            phase_reg[eval_idx_reg] <= PH_INFLIGHT;
                            found_reg               <= 1'b1;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (promote)
                        begin
                            phase_reg[eval_idx_reg] <= PH_READY;
                        end
                        if (take)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    ACT_PRESENT:
                    begin
                        // Free the presented slot whatever its phase.
                        if (drop || (eval_idx_reg == tgt_reg))
                        begin
                            phase_reg[eval_idx_reg] <= PH_FREE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction payload and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= action;
            tgt_reg      <= in_slot;
            scan_idx_reg <= '0;
            key_reg      <= '0;
            res_slot_reg <= '0;
            unique case (action) inside
                ACT_ACQUIRE, ACT_QUERY:
                    res_status_reg <= STAT_NONE;
                ACT_PUBLISH, ACT_COMPLETE, ACT_PRESENT:
                    res_status_reg <= in_bad ? STAT_BAD : STAT_OK;
                default:
                    res_status_reg <= STAT_OK;
            endcase
        end
        if (state_reg == S_SCAN)
        begin
            scan_idx_reg <= IDX_W'(scan_idx_reg + 1'b1);
        end
        eval_idx_reg <= scan_idx_reg;
        if (state_reg == S_LATCH)
        begin
            key_reg <= rd_data;
        end
        if (eval_vld_reg)
        begin
            if ((op_reg == ACT_ACQUIRE) && acq_hit)
            begin
                res_slot_reg   <= eval_idx_reg;
                res_status_reg <= STAT_OK;
            end
            if ((op_reg == ACT_QUERY) && take)
            begin
                res_slot_reg   <= eval_idx_reg;
                key_reg        <= rd_data;
                res_status_reg <= STAT_OK;
            end
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            status_reg    <= res_status_reg;
            slot_out_reg  <= SLOT_W'(res_slot_reg);
            frame_out_reg <= (op_reg == ACT_QUERY) ? key_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign frame_out = frame_out_reg;

    `FSMM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, in_stall, "accepted transaction did not hold off input")
    `FSMM_ASSERT_NXT(a_finish_loads, clk, rst_n, ((state_reg == S_FINISH) && out_free), out_valid_reg, "finished transaction not loaded into response")
    `FSMM_ASSERT_IMP(a_eval_in_scan, clk, rst_n, eval_vld_reg, ((state_reg == S_SCAN) || (state_reg == S_DRAIN)), "slot evaluation outside scan")
    `FSMM_ASSERT_IMP(a_bad_no_data, clk, rst_n, (out_valid_reg && (status_reg == STAT_BAD)), ((slot_out_reg == '0) && (frame_out_reg == '0)), "bad slot response carries data")

endmodule

// ===== tb/tb_frame_slot_mailbox_manager.sv =====
`timescale 1ns / 1ps

module tb_frame_slot_mailbox_manager;
    import fsmm_pkg::*;

    localparam int MAX_SLOTS = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_SETTING = 45;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [ACT_W-1:0] ACT_LAST_CODE = '1;
    localparam logic [IDX_IN_W-1:0] IDX_LAST = '1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
    } reply_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // Predicts each reply of the slot pool and checks the replies in order.
    class slot_pool_model;
        logic [CNT_W-1:0]   active;
        phase_t             phase [MAX_SLOTS];
        logic [FRAME_W-1:0] frame [MAX_SLOTS];
        bit                 finished [MAX_SLOTS];
        bit                 written [MAX_SLOTS];
        reply_t             expected_replies [$];
        int                 mismatches;

        function new();
            active = ACTIVE_RESET;
            mismatches = 0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                phase[i] = PH_FREE;
                frame[i] = '0;
                finished[i] = 1'b0;
                written[i] = 1'b0;
            end
        endfunction

        function int slots_in_use();
            return (int'(active) > MAX_SLOTS) ? MAX_SLOTS : int'(active);
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [IDX_IN_W-1:0] idx,
                                   logic [FRAME_W-1:0] frm, logic dn);
            reply_t             r;
            int                 n;
            int                 best;
            bit                 found;
            logic [FRAME_W-1:0] shown;
            r.status = STAT_OK;
            r.slot = '0;
            r.frame = '0;
            n = slots_in_use();
            found = 1'b0;
            best = 0;
            case (act)
                ACT_ACQUIRE:
                begin
                    r.status = STAT_NONE;
                    for (int i = 0; i < n && !found; i++)
                    begin
                        if (phase[i] == PH_FREE)
                        begin
                            phase[i] = PH_INFLIGHT;
                            r.status = STAT_OK;
                            r.slot = SLOT_W'(i);
                            found = 1'b1;
                        end
                    end
                end
                ACT_PUBLISH, ACT_COMPLETE, ACT_PRESENT:
                begin
                    if (int'(idx) >= n)
                        r.status = STAT_BAD;
                    else if (act == ACT_PUBLISH)
                    begin
                        frame[idx] = frm;
                        finished[idx] = dn;
                        phase[idx] = PH_PENDING;
                        written[idx] = 1'b1;
                    end
                    else if (act == ACT_COMPLETE)
                        finished[idx] = 1'b1;
                    else
                    begin
                        shown = frame[idx];
                        for (int i = 0; i < n; i++)
                            if (phase[i] == PH_READY && frame[i] <= shown)
                                phase[i] = PH_FREE;
                        phase[idx] = PH_FREE;
                    end
                end
                ACT_QUERY:
                begin
                    for (int i = 0; i < n; i++)
                        if (phase[i] == PH_PENDING && finished[i])
                            phase[i] = PH_READY;
                    // strict compare keeps the lowest index on a tie
                    for (int i = 0; i < n; i++)
                    begin
                        if (phase[i] == PH_READY && (!found || frame[i] > frame[best]))
                        begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        r.slot = SLOT_W'(best);
                        r.frame = frame[best];
                    end
                    else
                        r.status = STAT_NONE;
                end
                default:
                    ;
            endcase
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl,
                                  logic [FRAME_W-1:0] fr);
            reply_t e;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply: status %0d slot %0d frame %h",
                         $time, st, sl, fr);
                mismatches++;
                return;
            end
            e = expected_replies.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                mismatches++;
            end
            if (sl !== e.slot)
            begin
                $display("%0t: slot_out expected %0d actual %0d", $time, e.slot, sl);
                mismatches++;
            end
            if (fr !== e.frame)
            begin
                $display("%0t: frame_out expected %h actual %h", $time, e.frame, fr);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ACT_W-1:0]     action = '0;
    logic [IDX_IN_W-1:0]  slot_index = '0;
    logic [FRAME_W-1:0]   frame_number = '0;
    logic                 already_done = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [SLOT_W-1:0]    slot_out;
    logic [FRAME_W-1:0]   frame_out;

    slot_pool_model       pool;
    int                   cycles = 0;
    int                   burst_left = 1;
    int                   stall_cycle = 0;
    stall_mode_t          stall_mode = STALL_NONE;
    logic [FRAME_W-1:0]   frame_base = 64'd100;
    int                   cfg_plan [9] = '{4, 1, 0, 7, 2, 5, 6, 3, 4};

    frame_slot_mailbox_manager #(
        .MAX_SLOTS(MAX_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .slot_index(slot_index),
        .frame_number(frame_number),
        .already_done(already_done),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot_out(slot_out),
        .frame_out(frame_out)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            pool.note_request(action, slot_index, frame_number, already_done);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            pool.check_reply(status, slot_out, frame_out);

    // Switch the reply stall pattern at random, counting negedges in stall_cycle.
    always @(negedge clk)
    begin
        if (stall_cycle % 48 == 0)
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_cycle++;
        case (stall_mode)
            STALL_NONE:     out_stall = 1'b0;
            STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
            default:        out_stall = (stall_cycle % 3 != 0);
        endcase
    end

    task automatic push_request(input logic [ACT_W-1:0] act, input logic [IDX_IN_W-1:0] idx,
                                input logic [FRAME_W-1:0] frm, input logic dn);
        @(negedge clk);
        action = act;
        slot_index = idx;
        frame_number = frm;
        already_done = dn;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 10))
                @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = $urandom_range(1, 16);
        while (pool.expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_active(input int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = CNT_W'(value);
        @(posedge clk);
        pool.active = CNT_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [FRAME_W-1:0] pick_frame();
        int sel;
        int used [$];
        sel = $urandom_range(0, 9);
        for (int i = 0; i < MAX_SLOTS; i++)
            if (pool.written[i])
                used.push_back(i);
        if (sel < 4)
        begin
            frame_base += 64'($urandom_range(1, 3));
            return frame_base;
        end
        if (sel < 6 && used.size() != 0)
            return pool.frame[used[$urandom_range(0, used.size() - 1)]];
        if (sel < 7)
            return frame_base - 64'($urandom_range(0, 5));
        if (sel < 9)
            return {$urandom, $urandom};
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // Return a random in-range slot in the given phase, else the fallback.
    function automatic logic [IDX_IN_W-1:0] find_slot(phase_t ph, logic [IDX_IN_W-1:0] fallback);
        int hits [$];
        for (int i = 0; i < pool.slots_in_use(); i++)
            if (pool.phase[i] == ph)
                hits.push_back(i);
        if (hits.size() == 0)
            return fallback;
        return IDX_IN_W'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    // Present only slots holding a published frame, or out-of-range indexes.
    function automatic logic [IDX_IN_W-1:0] present_target();
        int n;
        int sel;
        int ready [$];
        int stored [$];
        n = pool.slots_in_use();
        sel = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            if (pool.written[i])
                stored.push_back(i);
            if (pool.written[i] && pool.phase[i] == PH_READY)
                ready.push_back(i);
        end
        if (sel < 6 && ready.size() != 0)
            return IDX_IN_W'(ready[$urandom_range(0, ready.size() - 1)]);
        if (sel < 9 && stored.size() != 0)
            return IDX_IN_W'(stored[$urandom_range(0, stored.size() - 1)]);
        return IDX_IN_W'($urandom_range(n, IDX_LAST));
    endfunction

    task automatic issue_random(output bit counted);
        int                  pick;
        logic [ACT_W-1:0]    act;
        logic [IDX_IN_W-1:0] idx;
        logic [FRAME_W-1:0]  frm;
        logic                dn;
        pick = $urandom_range(0, 99);
        idx = IDX_IN_W'($urandom_range(0, IDX_LAST));
        frm = pick_frame();
        dn = 1'($urandom_range(0, 1));
        counted = 1'b1;
        if (pick < 20)
            act = ACT_ACQUIRE;
        else if (pick < 45)
        begin
            act = ACT_PUBLISH;
            if ($urandom_range(0, 9) != 0)
                idx = find_slot(PH_INFLIGHT, idx);
        end
        else if (pick < 60)
        begin
            act = ACT_COMPLETE;
            if ($urandom_range(0, 9) != 0)
                idx = find_slot(PH_PENDING, idx);
        end
        else if (pick < 80)
            act = ACT_QUERY;
        else if (pick < 95)
        begin
            act = ACT_PRESENT;
            idx = present_target();
        end
        else
        begin
            act = ACT_W'($urandom_range(ACT_PRESENT + 1, ACT_LAST_CODE));
            counted = 1'b0;
        end
        push_request(act, idx, frm, dn);
    endtask

    initial
    begin
        int sent;
        bit counted;
        pool = new();
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Run at the reset slot count of three.
        push_request(ACT_QUERY, 3'd0, 64'd0, 1'b0);
        push_request(ACT_ACQUIRE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_ACQUIRE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_ACQUIRE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_ACQUIRE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_PUBLISH, 3'd0, 64'd0, 1'b1);
        push_request(ACT_PUBLISH, 3'd1, '1, 1'b0);
        push_request(ACT_PUBLISH, 3'd2, 64'd5, 1'b0);
        push_request(ACT_COMPLETE, 3'd3, 64'd0, 1'b0);
        push_request(ACT_PUBLISH, IDX_LAST, '1, 1'b1);
        push_request(ACT_PRESENT, IDX_LAST, 64'd0, 1'b0);
        push_request(ACT_QUERY, 3'd0, 64'd0, 1'b0);
        push_request(ACT_COMPLETE, 3'd1, 64'd0, 1'b0);
        push_request(ACT_COMPLETE, 3'd2, 64'd0, 1'b0);
        push_request(ACT_QUERY, 3'd0, 64'd0, 1'b0);
        push_request(ACT_W'(ACT_PRESENT + 1), 3'd2, '1, 1'b1);
        push_request(ACT_PRESENT, 3'd2, 64'd0, 1'b0);
        push_request(ACT_QUERY, 3'd0, 64'd0, 1'b0);
        // finish flag on a free slot is overwritten by the next publish
        push_request(ACT_COMPLETE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_PUBLISH, 3'd0, 64'd7, 1'b0);
        push_request(ACT_PRESENT, 3'd1, 64'd0, 1'b0);
        push_request(ACT_QUERY, 3'd0, 64'd0, 1'b0);
        push_request(ACT_ACQUIRE, 3'd0, 64'd0, 1'b0);
        push_request(ACT_LAST_CODE, 3'd5, 64'd0, 1'b1);

        foreach (cfg_plan[p])
        begin
            drain();
            write_active(cfg_plan[p]);
            sent = 0;
            while (sent < ITEMS_PER_SETTING)
            begin
                issue_random(counted);
                if (counted)
                    sent++;
            end
        end
        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (pool.expected_replies.size() != 0)
            $display("%0t: %0d replies never arrived", $time, pool.expected_replies.size());
        if (pool.mismatches == 0 && pool.expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
